/* hdl/zct_pkg.sv */
package zct_pkg;

    localparam int TIME_W  = 48;
    localparam int RATE_W  = 24;
    localparam int HALF_W  = 7;
    localparam int FREQ_W  = 34;
    localparam int QUO_W   = 35;
    localparam int ITER_W  = 6;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 24;
    // extra quotient bits beyond the time fraction: 7 for the scale, 1 for rounding
    localparam int FREQ_XSH = 8;

    localparam int DEF_MAX_HALF_CYCLES = 64;
    localparam int DEF_SAMPLE_BITS     = 24;
    localparam int DEF_TIME_FRAC_BITS  = 16;

    localparam logic [RATE_W-1:0] RST_SAMPLE_RATE = RATE_W'(16384);
    localparam logic [HALF_W-1:0] RST_HALF_CYCLES = HALF_W'(64);

    localparam logic [CIDX_W-1:0] REG_SAMPLE_RATE  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_HALF_CYCLES  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_COMPLEX_MODE = 2'd2;

    localparam logic [1:0] SIGN_NONE = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    localparam logic [QUO_W-1:0] FREQ_MAX = QUO_W'(34'h1FFFFFFFF);

    typedef struct packed {
        logic dload;
        logic tcap;
        logic trim;
        logic wr;
        logic chk;
        logic elap;
        logic fload;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic go;
        logic div_done;
        logic multi;
    } t_sts;

endpackage

/* hdl/zct_div.sv */
module zct_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [zct_pkg::TIME_W-1:0] i_rem,
    input  logic [zct_pkg::QUO_W-1:0]  i_low,
    input  logic [zct_pkg::TIME_W-1:0] i_den,
    input  logic [zct_pkg::ITER_W-1:0] i_iters,
    output logic                       o_done,
    output logic [zct_pkg::QUO_W-1:0]  o_quo
);

    logic [zct_pkg::TIME_W-1:0] r_rem;
    logic [zct_pkg::QUO_W-1:0]  r_low;
    logic [zct_pkg::QUO_W-1:0]  r_quo;
    logic [zct_pkg::TIME_W-1:0] r_den;
    logic [zct_pkg::ITER_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [zct_pkg::TIME_W:0]   w_trial;
    logic [zct_pkg::TIME_W:0]   w_diff;
    logic                       w_ge;

    // one restoring step per cycle
    assign w_trial = {r_rem, r_low[zct_pkg::QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == zct_pkg::ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_low <= i_low;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[zct_pkg::TIME_W-1:0] : w_trial[zct_pkg::TIME_W-1:0];
            r_low <= {r_low[zct_pkg::QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[zct_pkg::QUO_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* hdl/zct_dp.sv */
module zct_dp #(
    parameter int MAX_HALF_CYCLES = zct_pkg::DEF_MAX_HALF_CYCLES,
    parameter int SAMPLE_BITS     = zct_pkg::DEF_SAMPLE_BITS,
    parameter int TIME_FRAC_BITS  = zct_pkg::DEF_TIME_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_accept,
    input  logic [zct_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [zct_pkg::CDATA_W-1:0]   i_cfg_data,
    input  logic                          i_in_accept,
    input  logic signed [SAMPLE_BITS-1:0] i_real_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_imag_sample,
    input  logic                          i_block_start,
    input  logic                          i_restart,
    input  logic                          i_gap,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [zct_pkg::FREQ_W-1:0] o_frequency,
    input  zct_pkg::t_cmd                 i_cmd,
    output zct_pkg::t_sts                 o_sts
);

    localparam int DEPTH  = MAX_HALF_CYCLES + 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int A_W    = zct_pkg::RATE_W + CNT_W;
    localparam int FSH    = TIME_FRAC_BITS + zct_pkg::FREQ_XSH;
    localparam int FN_W   = A_W + FSH;
    localparam int DN_W   = SAMPLE_BITS + TIME_FRAC_BITS + 1;
    localparam int DEN_W  = SAMPLE_BITS + 1;
    localparam int QW     = zct_pkg::QUO_W;
    localparam int TW     = zct_pkg::TIME_W;

    logic [TW-1:0] r_mem [DEPTH];
    logic [TW-1:0] r_rd;

    logic [zct_pkg::RATE_W-1:0] r_rate;
    logic [zct_pkg::HALF_W-1:0] r_half;
    logic                       r_cplx;

    logic [1:0]                    r_sign;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic [TW-1:0]                 r_clock;
    logic [IDX_W-1:0]              r_head;
    logic [CNT_W-1:0]              r_count;
    logic signed [zct_pkg::FREQ_W-1:0] r_held;
    logic signed [zct_pkg::FREQ_W-1:0] r_out;
    logic                          r_out_valid;

    logic [SAMPLE_BITS-1:0] r_ax;
    logic [DEN_W-1:0]       r_den;
    logic [TW-1:0]          r_tclk;
    logic                   r_neg;
    logic [TW-1:0]          r_t;
    logic [A_W-1:0]         r_a;
    logic [TW-1:0]          r_e;
    logic                   r_ovf;
    logic                   r_azero;

    logic                   w_xneg, w_xpos, w_xzero, w_yzero;
    logic [1:0]             w_s0, w_s1, w_s2;
    logic                   w_clr, w_cross;
    logic [SAMPLE_BITS-1:0] w_ax, w_ap;
    logic [CNT_W-1:0]       w_heff;
    logic [CNT_W:0]         w_hsum;
    logic [CNT_W:0]         w_wsum;
    logic [IDX_W-1:0]       w_waddr;
    logic [DN_W-1:0]        w_dnum;
    logic [FN_W-1:0]        w_fnum;
    logic [TW-1:0]          w_fhi;
    logic [TW-1:0]          w_div_rem;
    logic [QW-1:0]          w_div_low;
    logic [TW-1:0]          w_div_den;
    logic [zct_pkg::ITER_W-1:0] w_div_iters;
    logic                   w_div_done;
    logic [QW-1:0]          w_quo;
    logic [QW:0]            w_rsum;
    logic [QW-1:0]          w_rnd;
    logic [QW-1:0]          w_fmag;
    logic signed [zct_pkg::FREQ_W-1:0] w_fval;

    // sign tracking for the sample being accepted
    assign w_xneg  = i_real_sample[SAMPLE_BITS-1];
    assign w_xzero = i_real_sample == '0;
    assign w_xpos  = !w_xneg && !w_xzero;
    assign w_yzero = i_imag_sample == '0;
    assign w_s0    = i_restart ? zct_pkg::SIGN_NONE : r_sign;
    assign w_s1    = (w_s0 != zct_pkg::SIGN_NONE) ? w_s0 :
                     w_xneg ? zct_pkg::SIGN_NEG :
                     w_xpos ? zct_pkg::SIGN_POS : zct_pkg::SIGN_NONE;
    assign w_clr   = i_block_start && w_xzero && (!r_cplx || w_yzero);
    assign w_s2    = w_clr ? zct_pkg::SIGN_NONE : w_s1;
    assign w_cross = ((w_s2 == zct_pkg::SIGN_POS) && w_xneg) ||
                     ((w_s2 == zct_pkg::SIGN_NEG) && w_xpos);
    assign w_ax    = w_xneg ? SAMPLE_BITS'(-i_real_sample) : SAMPLE_BITS'(i_real_sample);
    assign w_ap    = r_prev[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_prev) : SAMPLE_BITS'(r_prev);

    always_comb begin
        if (r_half == '0) begin
            w_heff = CNT_W'(1);
        end else if (int'(r_half) > MAX_HALF_CYCLES) begin
            w_heff = CNT_W'(MAX_HALF_CYCLES);
        end else begin
            w_heff = CNT_W'(r_half);
        end
    end

    assign w_hsum  = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count - w_heff);
    assign w_wsum  = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);
    assign w_waddr = (w_wsum >= (CNT_W+1)'(DEPTH)) ? IDX_W'(w_wsum - (CNT_W+1)'(DEPTH))
                                                   : IDX_W'(w_wsum);

    // crossing offset numerator, rounded half up by adding half the divisor
    assign w_dnum = {1'b0, r_ax, {TIME_FRAC_BITS{1'b0}}} + DN_W'(r_den >> 1);
    assign w_fnum = {r_a, {FSH{1'b0}}};
    assign w_fhi  = TW'(w_fnum[FN_W-1:QW]);

    always_comb begin
        if (i_cmd.dload) begin
            w_div_rem   = TW'(w_dnum[DN_W-1:TIME_FRAC_BITS+1]);
            w_div_low   = {w_dnum[TIME_FRAC_BITS:0], {(QW-TIME_FRAC_BITS-1){1'b0}}};
            w_div_den   = TW'(r_den);
            w_div_iters = zct_pkg::ITER_W'(TIME_FRAC_BITS + 1);
        end else begin
            w_div_rem   = w_fhi;
            w_div_low   = w_fnum[QW-1:0];
            w_div_den   = r_e;
            w_div_iters = zct_pkg::ITER_W'(QW);
        end
    end

    // the divider runs for every frequency, even one that overflows; an overflowing quotient is replaced by FREQ_MAX
    zct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.dload || i_cmd.fload),
        .i_rem   (w_div_rem),
        .i_low   (w_div_low),
        .i_den   (w_div_den),
        .i_iters (w_div_iters),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_rsum = {1'b0, w_quo} + (QW+1)'(1);
    assign w_rnd  = w_rsum[QW:1];
    always_comb begin
        if (r_azero) begin
            w_fmag = '0;
        end else if (r_ovf || (w_rnd > zct_pkg::FREQ_MAX)) begin
            w_fmag = zct_pkg::FREQ_MAX;
        end else begin
            w_fmag = w_rnd;
        end
    end
    assign w_fval = r_neg ? -$signed(zct_pkg::FREQ_W'(w_fmag))
                          : $signed(zct_pkg::FREQ_W'(w_fmag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= zct_pkg::RST_SAMPLE_RATE;
            r_half <= zct_pkg::RST_HALF_CYCLES;
            r_cplx <= 1'b0;
        end else if (i_cfg_accept) begin
            unique case (i_cfg_index)
                zct_pkg::REG_SAMPLE_RATE:  r_rate <= i_cfg_data[zct_pkg::RATE_W-1:0];
                zct_pkg::REG_HALF_CYCLES:  r_half <= i_cfg_data[zct_pkg::HALF_W-1:0];
                zct_pkg::REG_COMPLEX_MODE: r_cplx <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sign      <= zct_pkg::SIGN_NONE;
            r_prev      <= '0;
            r_clock     <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_in_accept) begin
                r_clock <= r_clock + 1'b1;
                if (i_gap) begin
                    r_sign  <= zct_pkg::SIGN_NONE;
                    r_count <= '0;
                end else begin
                    r_prev <= i_real_sample;
                    r_sign <= w_cross ? ~w_s2 + 2'd1 : w_s2;
                    if (i_restart || w_clr) begin
                        r_count <= '0;
                    end
                end
            end
            if (i_cmd.trim && (r_count > w_heff)) begin
                r_head  <= (w_hsum >= (CNT_W+1)'(DEPTH)) ? IDX_W'(w_hsum - (CNT_W+1)'(DEPTH))
                                                         : IDX_W'(w_hsum);
                r_count <= w_heff;
            end
            if (i_cmd.wr) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.fin) begin
                r_held <= w_fval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_out  <= i_gap ? '0 : r_held;
            r_ax   <= w_ax;
            r_den  <= DEN_W'(w_ax) + DEN_W'(w_ap);
            r_tclk <= r_clock;
            r_neg  <= r_cplx && !w_xzero && !w_yzero && (w_xneg == i_imag_sample[SAMPLE_BITS-1]);
        end
        if (i_cmd.tcap) begin
            r_t <= (r_tclk << TIME_FRAC_BITS) - TW'(w_quo[TIME_FRAC_BITS:0]);
        end
        if (i_cmd.chk) begin
            r_a <= A_W'(r_rate * (r_count - 1'b1));
        end
        if (i_cmd.elap) begin
            r_e <= r_t - r_rd;
        end
        if (i_cmd.fload) begin
            r_ovf   <= w_fhi >= r_e;
            r_azero <= r_a == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[w_waddr] <= r_t;
        end
        r_rd <= r_mem[r_head];
    end

    assign o_sts.go       = i_in_accept && !i_gap && w_cross;
    assign o_sts.div_done = w_div_done;
    assign o_sts.multi    = r_count != '0;
    assign o_out_valid    = r_out_valid;
    assign o_frequency    = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("crossing count beyond ring depth");
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_head) < DEPTH)
        else $error("ring head out of range");
    a_gap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_accept && i_gap) |=> (r_count == '0 && r_sign == zct_pkg::SIGN_NONE))
        else $error("gap did not clear history");

endmodule

/* hdl/zct_ctrl.sv */
module zct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  zct_pkg::t_sts i_sts,
    output zct_pkg::t_cmd o_cmd,
    output logic          o_idle
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DLOAD = 4'd1;
    localparam logic [3:0] S_DWAIT = 4'd2;
    localparam logic [3:0] S_TRIM  = 4'd3;
    localparam logic [3:0] S_WRITE = 4'd4;
    localparam logic [3:0] S_CHECK = 4'd5;
    localparam logic [3:0] S_ELAP  = 4'd6;
    localparam logic [3:0] S_FLOAD = 4'd7;
    localparam logic [3:0] S_FWAIT = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.go) n_state = S_DLOAD;
            end
            S_DLOAD: begin
                o_cmd.dload = 1'b1;
                n_state     = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.tcap = 1'b1;
                    n_state    = S_TRIM;
                end
            end
            S_TRIM: begin
                o_cmd.trim = 1'b1;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                // a second stored time is needed before a frequency exists
                n_state  = i_sts.multi ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                o_cmd.chk = 1'b1;
                n_state   = S_ELAP;
            end
            S_ELAP: begin
                o_cmd.elap = 1'b1;
                n_state    = S_FLOAD;
            end
            S_FLOAD: begin
                o_cmd.fload = 1'b1;
                n_state     = S_FWAIT;
            end
            S_FWAIT: begin
                if (i_sts.div_done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = r_state == S_IDLE;

endmodule

/* hdl/zero_crossing_frequency_tracker.sv */
// Zero-crossing frequency tracker. Every accepted sample returns one result: the frequency
// held before that sample, in Hz with 8 fractional bits (zero for a gap). A sample without
// a sign change leaves the controller idle. A sample with a crossing keeps the block busy
// while one shared shift-subtract divider first places the crossing (TIME_FRAC_BITS + 1
// steps), then, once two or more crossing times are stored, forms the frequency (35 steps).
// The crossing ring needs no clearing pass.
module zero_crossing_frequency_tracker #(
    parameter int MAX_HALF_CYCLES = zct_pkg::DEF_MAX_HALF_CYCLES,
    parameter int SAMPLE_BITS     = zct_pkg::DEF_SAMPLE_BITS,
    parameter int TIME_FRAC_BITS  = zct_pkg::DEF_TIME_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [zct_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [zct_pkg::CDATA_W-1:0]       i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [SAMPLE_BITS-1:0]     i_real_sample,
    input  logic signed [SAMPLE_BITS-1:0]     i_imag_sample,
    input  logic                              i_block_start,
    input  logic                              i_restart,
    input  logic                              i_gap,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [zct_pkg::FREQ_W-1:0] o_frequency
);

    zct_pkg::t_cmd w_cmd;
    zct_pkg::t_sts w_sts;
    logic          w_idle;
    logic          w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = w_idle && (!o_valid || i_ready);
    assign w_accept    = i_valid && o_ready;

    zct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_idle  (w_idle)
    );

    zct_dp #(
        .MAX_HALF_CYCLES (MAX_HALF_CYCLES),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .TIME_FRAC_BITS  (TIME_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_accept  (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_accept   (w_accept),
        .i_real_sample (i_real_sample),
        .i_imag_sample (i_imag_sample),
        .i_block_start (i_block_start),
        .i_restart     (i_restart),
        .i_gap         (i_gap),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_frequency   (o_frequency),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts)
    );

endmodule

/* sim/tb_zero_crossing_frequency_tracker.sv */
`timescale 1ns / 1ps

module tb_zero_crossing_frequency_tracker;

    localparam int RING = zct_pkg::DEF_MAX_HALF_CYCLES + 1;
    localparam int FRAC = zct_pkg::DEF_TIME_FRAC_BITS;
    localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;
    localparam longint FMAX = 64'h1_FFFF_FFFF;
    localparam int LIMIT = 400000;

    typedef struct {
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic bs;
        logic rs;
        logic gp;
    } t_sample;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [zct_pkg::CIDX_W-1:0] i_cfg_index;
    logic [zct_pkg::CDATA_W-1:0] i_cfg_data;
    logic i_valid;
    logic o_ready;
    logic signed [23:0] i_real_sample;
    logic signed [23:0] i_imag_sample;
    logic i_block_start;
    logic i_restart;
    logic i_gap;
    logic o_valid;
    logic i_ready;
    logic signed [zct_pkg::FREQ_W-1:0] o_frequency;

    zero_crossing_frequency_tracker uut (.*);

    t_sample pending_samples[$];
    logic signed [zct_pkg::FREQ_W-1:0] expected_freqs[$];
    int errors = 0;
    int cycles = 0;
    int n_checked = 0;
    int n_crossing_samples = 0;
    int stall_left = 0;
    bit stall_done = 0;

    // tracker shadow state
    longint unsigned rate_m;
    int half_m;
    bit cplx_m;
    longint unsigned times_m[RING];
    int head_m, count_m, sign_m;
    longint prev_m, held_m;
    longint unsigned clock_m;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit idle_now();
        // long quiet window with no idling
        if ((cycles % 12000) < 3000) return 0;
        return $urandom_range(99) < 18;
    endfunction

    function automatic longint rate_div(longint unsigned a, longint unsigned e);
        longint unsigned q, r;
        if (e == 0) return (a == 0) ? 0 : FMAX;
        q = a / e;
        r = a % e;
        for (int i = 0; i <= FRAC + 7; i++) begin
            if (q >= (64'd1 << 40)) return FMAX;
            r = r << 1;
            q = q << 1;
            if (r >= e) begin
                r = r - e;
                q = q | 1;
            end
        end
        q = (q + 1) >> 1;
        return (q > FMAX) ? FMAX : longint'(q);
    endfunction

    function automatic void push_crossing(longint unsigned t, longint x, longint y);
        int h;
        longint unsigned e;
        longint f;
        h = (half_m < 1) ? 1 : ((half_m > zct_pkg::DEF_MAX_HALF_CYCLES) ?
                                zct_pkg::DEF_MAX_HALF_CYCLES : half_m);
        while (count_m > h) begin
            head_m = (head_m + 1) % RING;
            count_m--;
        end
        times_m[(head_m + count_m) % RING] = t;
        count_m++;
        if (count_m > 1) begin
            e = (t - times_m[head_m]) & M48;
            f = rate_div(rate_m * longint'(count_m - 1), e);
            if (cplx_m && ((x > 0 && y > 0) || (x < 0 && y < 0))) f = -f;
            held_m = f;
        end
    endfunction

    function automatic logic signed [zct_pkg::FREQ_W-1:0] track_sample(t_sample s);
        longint x, y;
        longint unsigned ax, den, delta, t;
        logic signed [zct_pkg::FREQ_W-1:0] r;
        x = s.re;
        y = s.im;
        if (s.gp) begin
            count_m = 0;
            sign_m = 0;
            clock_m = (clock_m + 1) & M48;
            return '0;
        end
        r = held_m[zct_pkg::FREQ_W-1:0];
        if (s.rs) begin
            sign_m = 0;
            count_m = 0;
        end
        if (sign_m == 0) sign_m = (x < 0) ? -1 : ((x > 0) ? 1 : 0);
        if (s.bs && x == 0 && (!cplx_m || y == 0)) begin
            sign_m = 0;
            count_m = 0;
        end
        if ((sign_m > 0 && x < 0) || (sign_m < 0 && x > 0)) begin
            ax = (x < 0) ? -x : x;
            den = ax + ((prev_m < 0) ? -prev_m : prev_m);
            delta = ((ax << FRAC) + den / 2) / den;
            t = ((clock_m << FRAC) - delta) & M48;
            sign_m = -sign_m;
            push_crossing(t, x, y);
            n_crossing_samples++;
        end
        prev_m = x;
        clock_m = (clock_m + 1) & M48;
        return r;
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        t_sample s;
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                s.re = i_real_sample;
                s.im = i_imag_sample;
                s.bs = i_block_start;
                s.rs = i_restart;
                s.gp = i_gap;
                expected_freqs.push_back(track_sample(s));
            end
            if (pending_samples.size() > 0 && !idle_now()) begin
                s = pending_samples.pop_front();
                i_valid <= 1;
                i_real_sample <= s.re;
                i_imag_sample <= s.im;
                i_block_start <= s.bs;
                i_restart <= s.rs;
                i_gap <= s.gp;
            end else begin
                i_valid <= 0;
            end
        end
    end

    task automatic report_mismatch(string msg);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // result monitor, with one long hold-off to back the block up
    always @(posedge i_clk) begin
        logic signed [zct_pkg::FREQ_W-1:0] want;
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_freqs.size() == 0) begin
                    report_mismatch($sformatf("unexpected frequency %0d", o_frequency));
                end else begin
                    want = expected_freqs.pop_front();
                    n_checked++;
                    if (o_frequency !== want)
                        report_mismatch($sformatf("frequency %0d, expected %0d",
                                                  o_frequency, want));
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready <= 0;
            end else if (!stall_done && n_checked == 200) begin
                stall_done <= 1;
                stall_left <= 600;
                i_ready <= 0;
            end else begin
                i_ready <= !idle_now();
            end
        end
    end

    task automatic cfg_write(logic [zct_pkg::CIDX_W-1:0] idx, int unsigned value);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= value[zct_pkg::CDATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            zct_pkg::REG_SAMPLE_RATE: rate_m = value & 24'hFFFFFF;
            zct_pkg::REG_HALF_CYCLES: half_m = value & 7'h7F;
            zct_pkg::REG_COMPLEX_MODE: cplx_m = value & 1;
            default: ;
        endcase
        i_cfg_valid <= 0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_samples.size() != 0 || i_valid || expected_freqs.size() != 0);
        // a crossing may still be in the divider
        repeat (80) @(posedge i_clk);
    endtask

    function automatic void add_sample(int re, int im, bit bs, bit rs, bit gp);
        t_sample s;
        s.re = re[23:0];
        s.im = im[23:0];
        s.bs = bs;
        s.rs = rs;
        s.gp = gp;
        pending_samples.push_back(s);
    endfunction

    // alternating-sign waveform with random lengths, magnitudes and flags
    function automatic void add_waves(int n);
        int run, left, pol, amp, v, k;
        pol = 1;
        left = 0;
        run = 1;
        amp = 100;
        for (int i = 0; i < n; i++) begin
            if (left == 0) begin
                pol = -pol;
                if ($urandom_range(9) == 0) run = $urandom_range(1, 40);
                else if ($urandom_range(3) == 0) run = $urandom_range(1, 10);
                left = $urandom_range(1, run);
                k = $urandom_range(3);
                amp = (k == 0) ? 8388607 : ((k == 1) ? 255 : $urandom_range(1, 70000));
            end
            left--;
            k = $urandom_range(99);
            if (k < 4) begin
                // full random noise sample
                add_sample($urandom, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            end else begin
                v = $urandom_range(1, amp);
                if (k < 9) v = 0;
                if (pol < 0) v = (v == 8388607 && $urandom_range(1)) ? -8388608 : -v;
                add_sample(v, $urandom_range(7) == 0 ? 0 : int'($urandom),
                           $urandom_range(29) == 0, $urandom_range(39) == 0,
                           $urandom_range(39) == 0);
            end
        end
    endfunction

    initial begin
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 0;
        i_ready = 0;
        i_real_sample = '0;
        i_imag_sample = '0;
        i_block_start = 0;
        i_restart = 0;
        i_gap = 0;
        rate_m = zct_pkg::RST_SAMPLE_RATE;
        half_m = zct_pkg::RST_HALF_CYCLES;
        cplx_m = 0;
        foreach (times_m[i]) times_m[i] = 0;
        head_m = 0;
        count_m = 0;
        sign_m = 0;
        prev_m = 0;
        held_m = 0;
        clock_m = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: zero block start, extremes, zero before crossing, restart, gap
        add_sample(0, 0, 1, 0, 0);
        add_sample(8388607, -8388608, 0, 0, 0);
        add_sample(-8388608, 8388607, 0, 0, 0);
        add_sample(8388607, 1, 0, 0, 0);
        add_sample(0, 0, 0, 0, 0);
        add_sample(-3, -1, 0, 0, 0);
        add_sample(5, 7, 0, 0, 0);
        add_sample(-1, 0, 0, 0, 0);
        add_sample(0, 5, 1, 0, 0);
        add_sample(1, 1, 0, 0, 0);
        add_sample(-1, -1, 0, 1, 0);
        add_sample(1, 0, 0, 0, 0);
        add_sample(-8388608, -8388608, 1, 1, 1);
        add_sample(2, 0, 0, 0, 0);
        add_sample(-2, 0, 0, 0, 0);
        add_sample(2, 0, 0, 0, 0);
        add_waves(140);
        wait_drained();

        cfg_write(zct_pkg::REG_SAMPLE_RATE, 24'hFFFFFF);
        cfg_write(zct_pkg::REG_HALF_CYCLES, 1);
        cfg_write(zct_pkg::REG_COMPLEX_MODE, 1);
        add_sample(5, 5, 0, 0, 0);
        add_sample(-5, -5, 0, 0, 0);
        add_sample(5, -5, 0, 0, 0);
        add_sample(0, 3, 1, 0, 0);
        add_sample(0, 0, 1, 0, 0);
        add_waves(120);
        wait_drained();

        cfg_write(zct_pkg::REG_SAMPLE_RATE, 0);
        cfg_write(zct_pkg::REG_HALF_CYCLES, 0);
        cfg_write(zct_pkg::REG_COMPLEX_MODE, 0);
        add_waves(60);
        wait_drained();

        cfg_write(zct_pkg::REG_SAMPLE_RATE, 1);
        cfg_write(zct_pkg::REG_HALF_CYCLES, 127);
        cfg_write(zct_pkg::REG_COMPLEX_MODE, 1);
        add_waves(100);
        wait_drained();

        cfg_write(zct_pkg::REG_SAMPLE_RATE, 48000);
        cfg_write(zct_pkg::REG_HALF_CYCLES, 3);
        cfg_write(zct_pkg::CIDX_W'(3), 24'h5A5A5A);
        add_waves(120);
        wait_drained();

        $display("checked %0d frequencies, %0d samples with a crossing, 5 register settings",
                 n_checked, n_crossing_samples);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", errors);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/zct_pkg.sv
hdl/zct_div.sv
hdl/zct_dp.sv
hdl/zct_ctrl.sv
hdl/zero_crossing_frequency_tracker.sv
sim/tb_zero_crossing_frequency_tracker.sv
